### rtl/pmlod_pkg.sv
// ----------------------------------------------------------------------------
// pmlod_pkg
// Shared types and constants of the progressive mesh LOD index updater:
// item kinds, register indexes, the packed collapse record and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pmlod_pkg;

  typedef enum logic [2:0] {
    KIND_LOAD_COLLAPSE = 3'd0,
    KIND_LOAD_CHANGE   = 3'd1,
    KIND_LOAD_INDEX    = 3'd2,
    KIND_LOAD_POINT    = 3'd3,
    KIND_RESTART       = 3'd4,
    KIND_SET_VERTICES  = 3'd5,
    KIND_SET_DISTANCE  = 3'd6,
    KIND_READ_INDEX    = 3'd7
  } kind_t;

  localparam logic [1:0] CFG_COLLAPSE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_BASE_VERTICES   = 2'd1;
  localparam logic [1:0] CFG_BASE_INDICES    = 2'd2;
  localparam logic [1:0] CFG_LOD_POINT_COUNT = 2'd3;

  localparam logic [31:0] FULL_DETAIL = 32'h7fff_ffff;
  localparam int          DIV_BITS    = 48;

  typedef struct packed {
    logic        force_split;
    logic [15:0] collapse_target;
    logic [13:0] change_count;
    logic [13:0] change_start;
    logic [13:0] indices_to_lose;
    logic [15:0] verts_to_lose;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic tgt_value;
    logic tgt_full;
    logic tgt_point;
    logic tgt_interp;
    logic lod_eval;
    logic lod_next;
    logic mul;
    logic div_step;
    logic fetch;
    logic fetch_dn;
    logic split;
    logic collapse;
    logic rw_step;
    logic rd_capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  lod_none;
    logic  lod_first_lt;
    logic  lod_last;
    logic  lod_last_below;
    logic  lod_found;
    logic  div_done;
    logic  tgt_gt_av;
    logic  tgt_lt_av;
    logic  sp_zero;
    logic  sp_ge_eff;
    logic  rec_over;
    logic  rec_force;
    logic  rw_done;
  } sts_t;

endpackage

`default_nettype wire

### rtl/pmlod_ram.sv
// ----------------------------------------------------------------------------
// pmlod_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmlod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/pmlod_dp.sv
// ----------------------------------------------------------------------------
// pmlod_dp
// Datapath: configuration, tables, counts, LOD interpolation with a
// bit-serial divider, and the index rewrite pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pmlod_dp #(
  parameter int MAX_INDICES   = 8192,
  parameter int MAX_COLLAPSES = 2048,
  parameter int MAX_CHANGES   = 16384,
  parameter int LOD_POINTS    = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic [2:0]       in_kind,
  input  wire logic [13:0]      in_addr,
  input  wire logic [15:0]      in_value,
  input  wire logic [31:0]      in_distance,
  input  wire logic [15:0]      in_verts_to_lose,
  input  wire logic [13:0]      in_indices_to_lose,
  input  wire logic [13:0]      in_change_start,
  input  wire logic [13:0]      in_change_count,
  input  wire logic [15:0]      in_collapse_target,
  input  wire logic             in_force_split,
  input  wire pmlod_pkg::cmd_t  cmd,
  output pmlod_pkg::sts_t       sts,
  output logic [15:0]           out_read_data,
  output logic [15:0]           out_vertex_count,
  output logic [13:0]           out_index_count,
  output logic [11:0]           out_level_position
);

  localparam int IW = $clog2(MAX_INDICES);
  localparam int CW = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;
  localparam int RW = $clog2(MAX_COLLAPSES + 1);
  localparam int LW = (LOD_POINTS > 1) ? $clog2(LOD_POINTS) : 1;
  localparam int NW = $clog2(LOD_POINTS + 1);

  // captured transaction
  pmlod_pkg::kind_t kind_r;
  logic [13:0]      addr_r;
  logic [15:0]      value_r;
  logic [31:0]      dist_r;
  pmlod_pkg::rec_t  rec_in_r;

  logic [11:0] cc_r;
  logic [15:0] bv_r;
  logic [13:0] bi_r;
  logic [3:0]  lpc_r;

  logic [15:0] av_r;
  logic [13:0] ai_r;
  logic [11:0] sp_r;
  logic [31:0] tgt_r;

  logic        rd_ok_r;
  logic [15:0] rd_r;

  logic [LW-1:0] idx_r;
  logic          found_r;
  logic [31:0]   lo_d_r, hi_d_r;
  logic [15:0]   lo_v_r, hi_v_r;

  logic        neg_r;
  logic [31:0] span_r;
  logic [47:0] quo_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;

  logic        rec_ok_r;
  logic [15:0] rw_val_r;
  logic [13:0] rw_start_r, rw_cnt_r, rw_k_r;
  logic        pend_r;

  logic [$bits(pmlod_pkg::rec_t)-1:0] ct_q;
  logic [12:0] cl_q;
  logic [15:0] ix_q;
  logic [47:0] pt_q;

  logic [11:0]     eff;
  logic [NW-1:0]   n_eff;
  pmlod_pkg::rec_t rec;
  logic [31:0]     pd;
  logic [15:0]     pv;
  logic            lt_now;
  logic [11:0]     fetch_pos;
  logic [14:0]     rw_e;
  logic            rw_more, rw_issue;
  logic [16:0]     dv;
  logic [15:0]     mag;
  logic [47:0]     prod;
  logic [32:0]     rem_sh;
  logic            ge;
  logic [15:0]     q;

  assign eff   = (32'(cc_r) > MAX_COLLAPSES) ? 12'(MAX_COLLAPSES) : cc_r;
  assign n_eff = (32'(lpc_r) > LOD_POINTS) ? NW'(LOD_POINTS) : NW'(lpc_r);
  assign rec   = rec_ok_r ? pmlod_pkg::rec_t'(ct_q) : '0;
  assign pd    = pt_q[47:16];
  assign pv    = pt_q[15:0];
  assign lt_now = dist_r < pd;
  assign fetch_pos = cmd.fetch_dn ? (sp_r - 12'd1) : sp_r;

  assign rw_e     = 15'(rw_start_r) + 15'(rw_k_r);
  assign rw_more  = rw_k_r < rw_cnt_r;
  assign rw_issue = cmd.rw_step && rw_more && (32'(rw_e) < MAX_CHANGES);

  assign dv   = {1'b0, hi_v_r} - {1'b0, lo_v_r};
  assign mag  = dv[16] ? 16'(-dv) : dv[15:0];
  assign prod = mag * (dist_r - lo_d_r);

  assign rem_sh = {rem_r, quo_r[47]};
  assign ge     = rem_sh >= {1'b0, span_r};
  assign q      = quo_r[15:0];

  always_comb begin
    sts.kind           = kind_r;
    sts.lod_none       = (n_eff == '0);
    sts.lod_first_lt   = (idx_r == '0) && lt_now;
    sts.lod_last       = (32'(idx_r) + 32'd1) == 32'(n_eff);
    sts.lod_last_below = pd < dist_r;
    sts.lod_found      = found_r || ((idx_r != '0) && lt_now);
    sts.div_done       = cnt_r == 6'(pmlod_pkg::DIV_BITS);
    sts.tgt_gt_av      = tgt_r > 32'(av_r);
    sts.tgt_lt_av      = tgt_r < 32'(av_r);
    sts.sp_zero        = sp_r == '0;
    sts.sp_ge_eff      = sp_r >= eff;
    sts.rec_over       = (32'(rec.verts_to_lose) + 32'(av_r)) > tgt_r;
    sts.rec_force      = rec.force_split;
    sts.rw_done        = !rw_more && !pend_r;
  end

  // ---- tables ----
  logic          ct_we, cl_we, ix_we, ix_ld, pt_we, pt_re;
  logic [IW-1:0] ix_wa;
  logic [15:0]   ix_wd;

  assign ct_we = cmd.exec && (kind_r == pmlod_pkg::KIND_LOAD_COLLAPSE) &&
                 (32'(addr_r) <= MAX_COLLAPSES);
  assign cl_we = cmd.exec && (kind_r == pmlod_pkg::KIND_LOAD_CHANGE) &&
                 (32'(addr_r) < MAX_CHANGES);
  assign ix_ld = cmd.exec && (kind_r == pmlod_pkg::KIND_LOAD_INDEX) &&
                 (32'(addr_r) < MAX_INDICES);
  assign ix_we = ix_ld || (pend_r && (32'(cl_q) < MAX_INDICES));
  assign ix_wa = ix_ld ? IW'(addr_r) : IW'(cl_q);
  assign ix_wd = ix_ld ? value_r : rw_val_r;
  assign pt_we = cmd.exec && (kind_r == pmlod_pkg::KIND_LOAD_POINT) &&
                 (32'(addr_r) < LOD_POINTS);
  assign pt_re = (cmd.exec && (kind_r == pmlod_pkg::KIND_SET_DISTANCE)) || cmd.lod_next;

  pmlod_ram #(.WIDTH($bits(pmlod_pkg::rec_t)), .DEPTH(MAX_COLLAPSES + 1)) u_collapse (
    .clk(clk), .wr_en(ct_we), .wr_addr(RW'(addr_r)), .wr_data(rec_in_r),
    .rd_en(cmd.fetch), .rd_addr(RW'(fetch_pos)), .rd_data(ct_q)
  );

  pmlod_ram #(.WIDTH(13), .DEPTH(MAX_CHANGES)) u_change (
    .clk(clk), .wr_en(cl_we), .wr_addr(CW'(addr_r)), .wr_data(value_r[12:0]),
    .rd_en(rw_issue), .rd_addr(CW'(rw_e)), .rd_data(cl_q)
  );

  pmlod_ram #(.WIDTH(16), .DEPTH(MAX_INDICES)) u_index (
    .clk(clk), .wr_en(ix_we), .wr_addr(ix_wa), .wr_data(ix_wd),
    .rd_en(cmd.exec && (kind_r == pmlod_pkg::KIND_READ_INDEX)),
    .rd_addr(IW'(addr_r)), .rd_data(ix_q)
  );

  pmlod_ram #(.WIDTH(48), .DEPTH(LOD_POINTS)) u_point (
    .clk(clk), .wr_en(pt_we), .wr_addr(LW'(addr_r)), .wr_data({dist_r, value_r}),
    .rd_en(pt_re), .rd_addr(cmd.lod_next ? LW'(32'(idx_r) + 32'd1) : '0),
    .rd_data(pt_q)
  );

  // ---- item capture and config ----
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r                   <= pmlod_pkg::kind_t'(in_kind);
      addr_r                   <= in_addr;
      value_r                  <= in_value;
      dist_r                   <= in_distance;
      rec_in_r.verts_to_lose   <= in_verts_to_lose;
      rec_in_r.indices_to_lose <= in_indices_to_lose;
      rec_in_r.change_start    <= in_change_start;
      rec_in_r.change_count    <= in_change_count;
      rec_in_r.collapse_target <= in_collapse_target;
      rec_in_r.force_split     <= in_force_split;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= '0;
      bv_r  <= '0;
      bi_r  <= '0;
      lpc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pmlod_pkg::CFG_COLLAPSE_COUNT:  cc_r  <= cfg_data[11:0];
        pmlod_pkg::CFG_BASE_VERTICES:   bv_r  <= cfg_data;
        pmlod_pkg::CFG_BASE_INDICES:    bi_r  <= cfg_data[13:0];
        pmlod_pkg::CFG_LOD_POINT_COUNT: lpc_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---- level counts ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= '0;
      ai_r <= '0;
      sp_r <= '0;
    end else if (cmd.exec && (kind_r == pmlod_pkg::KIND_RESTART)) begin
      av_r <= bv_r;
      ai_r <= bi_r;
      sp_r <= '0;
    end else if (cmd.split) begin
      av_r <= av_r + rec.verts_to_lose;
      ai_r <= ai_r + rec.indices_to_lose;
      sp_r <= sp_r + 12'd1;
    end else if (cmd.collapse) begin
      av_r <= av_r - rec.verts_to_lose;
      ai_r <= ai_r - rec.indices_to_lose;
      sp_r <= sp_r - 12'd1;
    end
  end

  // ---- target ----
  always_ff @(posedge clk) begin
    if (cmd.tgt_value) begin
      tgt_r <= 32'(value_r);
    end else if (cmd.tgt_full) begin
      tgt_r <= pmlod_pkg::FULL_DETAIL;
    end else if (cmd.tgt_point) begin
      tgt_r <= 32'(pv);
    end else if (cmd.tgt_interp) begin
      if (span_r == '0) begin
        tgt_r <= 32'(lo_v_r);
      end else if (neg_r) begin
        tgt_r <= 32'(lo_v_r) - 32'(q);
      end else begin
        tgt_r <= 32'(lo_v_r) + 32'(q);
      end
    end
  end

  // ---- lod point scan ----
  always_ff @(posedge clk) begin
    if (cmd.exec && (kind_r == pmlod_pkg::KIND_SET_DISTANCE)) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.lod_eval && !found_r) begin
        if ((idx_r != '0) && lt_now) begin
          found_r <= 1'b1;
          hi_d_r  <= pd;
          hi_v_r  <= pv;
        end else begin
          lo_d_r <= pd;
          lo_v_r <= pv;
        end
      end
      if (cmd.lod_next) begin
        idx_r <= LW'(32'(idx_r) + 32'd1);
      end
    end
  end

  // ---- multiply then restoring divide, one quotient bit a cycle ----
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg_r  <= dv[16];
      span_r <= hi_d_r - lo_d_r;
      quo_r  <= prod;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, span_r}) : rem_sh[31:0];
      quo_r <= {quo_r[46:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  // ---- record fetch and index rewrite ----
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rec_ok_r <= fetch_pos < eff;
    end
    if (cmd.split || cmd.collapse) begin
      rw_k_r     <= '0;
      rw_start_r <= rec.change_start;
      rw_cnt_r   <= rec.change_count;
      rw_val_r   <= cmd.split ? (av_r + rec.verts_to_lose - 16'd1) : rec.collapse_target;
    end else if (cmd.rw_step && rw_more) begin
      rw_k_r <= rw_k_r + 14'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= rw_issue;
    end
  end

  // ---- read and result ----
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r    <= '0;
      rd_ok_r <= (32'(addr_r) < 32'(ai_r)) && (32'(addr_r) < MAX_INDICES);
    end else if (cmd.rd_capture) begin
      rd_r <= rd_ok_r ? ix_q : '0;
    end
    if (cmd.out_load) begin
      out_read_data      <= rd_r;
      out_vertex_count   <= av_r;
      out_index_count    <= ai_r;
      out_level_position <= sp_r;
    end
  end

endmodule

`default_nettype wire

### rtl/pmlod_ctrl.sv
// ----------------------------------------------------------------------------
// pmlod_ctrl
// Controller: sequences each transaction through load, read, distance
// interpolation and the split/collapse walk, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pmlod_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire pmlod_pkg::sts_t sts,
  output pmlod_pkg::cmd_t      cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_EXEC  = 11'b000_0000_0010,
    S_READ  = 11'b000_0000_0100,
    S_LOD   = 11'b000_0000_1000,
    S_MUL   = 11'b000_0001_0000,
    S_DIV   = 11'b000_0010_0000,
    S_CMP   = 11'b000_0100_0000,
    S_FETCH = 11'b000_1000_0000,
    S_REC   = 11'b001_0000_0000,
    S_RW    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    MODE_UP    = 2'd0,
    MODE_DOWN  = 2'd1,
    MODE_FORCE = 2'd2
  } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.kind)
          pmlod_pkg::KIND_SET_VERTICES: begin
            cmd.tgt_value = 1'b1;
            state_nxt     = S_CMP;
          end
          pmlod_pkg::KIND_SET_DISTANCE: begin
            if (sts.lod_none) begin
              cmd.tgt_full = 1'b1;
              state_nxt    = S_CMP;
            end else begin
              state_nxt = S_LOD;
            end
          end
          pmlod_pkg::KIND_READ_INDEX: state_nxt = S_READ;
          default:                    state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_LOD: begin
        cmd.lod_eval = 1'b1;
        if (sts.lod_first_lt) begin
          cmd.tgt_point = 1'b1;
          state_nxt     = S_CMP;
        end else if (sts.lod_last) begin
          if (sts.lod_last_below) begin
            cmd.tgt_point = 1'b1;
            state_nxt     = S_CMP;
          end else if (sts.lod_found) begin
            state_nxt = S_MUL;
          end else begin
            // distance not bracketed: counts stay as they are
            state_nxt = S_DONE;
          end
        end else begin
          cmd.lod_next = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.tgt_interp = 1'b1;
          state_nxt      = S_CMP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CMP: begin
        if (sts.tgt_gt_av) begin
          mode_nxt  = MODE_UP;
          state_nxt = S_FETCH;
        end else if (sts.tgt_lt_av) begin
          mode_nxt  = MODE_DOWN;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FETCH: begin
        if ((mode_r == MODE_UP) && !sts.tgt_gt_av) begin
          mode_nxt = MODE_FORCE;
        end else if ((mode_r == MODE_DOWN) && (!sts.tgt_lt_av || sts.sp_zero)) begin
          mode_nxt = MODE_FORCE;
        end
        cmd.fetch    = 1'b1;
        cmd.fetch_dn = mode_nxt == MODE_DOWN;
        state_nxt    = S_REC;
      end
      S_REC: begin
        case (mode_r)
          MODE_UP: begin
            if (sts.rec_over || sts.sp_ge_eff) begin
              mode_nxt  = MODE_FORCE;
              state_nxt = S_FETCH;
            end else begin
              cmd.split = 1'b1;
              state_nxt = S_RW;
            end
          end
          MODE_DOWN: begin
            cmd.collapse = 1'b1;
            state_nxt    = S_RW;
          end
          default: begin
            if (sts.rec_force && !sts.sp_ge_eff) begin
              cmd.split = 1'b1;
              state_nxt = S_RW;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end
      S_RW: begin
        cmd.rw_step = 1'b1;
        if (sts.rw_done) begin
          state_nxt = S_FETCH;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_UP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/progressive_mesh_lod_index_update_core.sv
// ----------------------------------------------------------------------------
// progressive_mesh_lod_index_update_core
// Loads and reads: one transaction in flight at a time; a load goes from the
// execute state to the result, a read through the index read state as well.
// Set vertices: each split/collapse step fetches a record, then rewrites the
// indices of its change list through the change-list port.
// Set distance adds a scan over the LOD points and the serial divider.
// Synchronous reset clears counts and config; tables hold junk until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module progressive_mesh_lod_index_update_core #(
  parameter int MAX_INDICES   = 8192,
  parameter int MAX_COLLAPSES = 2048,
  parameter int MAX_CHANGES   = 16384,
  parameter int LOD_POINTS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [13:0] in_addr,
  input  wire logic [15:0] in_value,
  input  wire logic [31:0] in_distance,
  input  wire logic [15:0] in_verts_to_lose,
  input  wire logic [13:0] in_indices_to_lose,
  input  wire logic [13:0] in_change_start,
  input  wire logic [13:0] in_change_count,
  input  wire logic [15:0] in_collapse_target,
  input  wire logic        in_force_split,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data,
  output logic [15:0]      out_vertex_count,
  output logic [13:0]      out_index_count,
  output logic [11:0]      out_level_position
);

  pmlod_pkg::cmd_t cmd;
  pmlod_pkg::sts_t sts;

  pmlod_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  pmlod_dp #(
    .MAX_INDICES(MAX_INDICES), .MAX_COLLAPSES(MAX_COLLAPSES),
    .MAX_CHANGES(MAX_CHANGES), .LOD_POINTS(LOD_POINTS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_kind(in_kind), .in_addr(in_addr), .in_value(in_value),
    .in_distance(in_distance), .in_verts_to_lose(in_verts_to_lose),
    .in_indices_to_lose(in_indices_to_lose), .in_change_start(in_change_start),
    .in_change_count(in_change_count), .in_collapse_target(in_collapse_target),
    .in_force_split(in_force_split),
    .cmd(cmd), .sts(sts),
    .out_read_data(out_read_data), .out_vertex_count(out_vertex_count),
    .out_index_count(out_index_count), .out_level_position(out_level_position)
  );

endmodule

`default_nettype wire

### rtl/pmlod_checker.sv
// ----------------------------------------------------------------------------
// pmlod_checker
// Port-level checks on the LOD index updater, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pmlod_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_read_data
);

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in progress");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_read_data))
    else $error("stalled result changed");

endmodule

bind progressive_mesh_lod_index_update_core pmlod_checker u_pmlod_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data)
);

`default_nettype wire
